// ===== design/rbst_pkg.sv =====
// Shared types, constants and single-precision helpers for the ray box slab test.
package rbst_pkg;

	typedef logic [31:0] f32_t;

	localparam f32_t PAR_LIMIT = 32'h2B8CBCCC;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_BOX  = 1'b1;

	localparam logic [1:0] ST_MISS    = 2'd0;
	localparam logic [1:0] ST_HIT     = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic        sign;
		logic        zsign;
		logic [9:0]  exp;
		logic [27:0] sum;
	} fadd_pre_t;

	typedef struct packed {
		logic               sign;
		logic               inf;
		logic signed [10:0] exp;
		logic [47:0]        prod;
	} fmul_pre_t;

	typedef struct packed {
		logic par;
		logic pmiss;
		f32_t near;
		f32_t far;
	} slab_t;

	typedef struct packed {
		logic ok;
		logic miss;
		f32_t enter;
		f32_t leave;
	} trk_t;

	function automatic logic fp_finite(input f32_t a);
		return a[30:23] != 8'hFF;
	endfunction

	function automatic logic fp_lt(input f32_t a, input f32_t b);
		logic an;
		logic bn;
		an = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
		bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
		if (an || bn)
			return 1'b0;
		if ((a[30:0] == 31'h0) && (b[30:0] == 31'h0))
			return 1'b0;
		if (a[31] != b[31])
			return a[31];
		if (!a[31])
			return a[30:0] < b[30:0];
		return a[30:0] > b[30:0];
	endfunction

	function automatic f32_t round_pack(input logic sgn, input logic signed [10:0] e,
			input logic [26:0] sig, input logic stk);
		logic [23:0] keep;
		logic        up;
		logic [7:0]  fld;
		logic [30:0] word;
		keep = sig[26:3];
		up   = sig[2] & (sig[1] | sig[0] | stk | keep[0]);
		fld  = keep[23] ? e[7:0] : 8'h00;
		word = {fld, keep[22:0]} + {30'h0, up};
		if (e > 11'sd254)
			return {sgn, 8'hFF, 23'h0};
		return {sgn, word};
	endfunction

	function automatic fadd_pre_t fp_add_pre(input f32_t a, input f32_t b);
		f32_t        x;
		f32_t        y;
		logic [7:0]  ex;
		logic [7:0]  ey;
		logic [7:0]  d;
		logic [4:0]  dc;
		logic [23:0] sx;
		logic [23:0] sy;
		logic [59:0] tmp;
		logic [26:0] ay;
		fadd_pre_t   p;
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex  = (x[30:23] == 8'h0) ? 8'd1 : x[30:23];
		ey  = (y[30:23] == 8'h0) ? 8'd1 : y[30:23];
		sx  = {x[30:23] != 8'h0, x[22:0]};
		sy  = {y[30:23] != 8'h0, y[22:0]};
		d   = ex - ey;
		dc  = (d > 8'd31) ? 5'd31 : d[4:0];
		tmp = {sy, 36'h0} >> dc;
		ay  = tmp[59:33] | {26'h0, |tmp[32:0]};
		p.sign = x[31];
		p.exp  = {2'b00, ex};
		if (x[31] ^ y[31]) begin
			p.sum   = {1'b0, sx, 3'b000} - {1'b0, ay};
			p.zsign = 1'b0;
		end else begin
			p.sum   = {1'b0, sx, 3'b000} + {1'b0, ay};
			p.zsign = x[31];
		end
		return p;
	endfunction

	function automatic f32_t fp_add_post(input fadd_pre_t p);
		logic [4:0]         lz;
		logic [4:0]         sh;
		logic [26:0]        sig;
		logic signed [10:0] e;
		if (p.sum == 28'h0)
			return {p.zsign, 31'h0};
		if (p.sum[27]) begin
			sig = {p.sum[27:2], p.sum[1] | p.sum[0]};
			e   = $signed({1'b0, p.exp}) + 11'sd1;
		end else begin
			lz = 5'd27;
			for (int i = 0; i < 27; i++)
				if (p.sum[i])
					lz = 5'(26 - i);
			sh  = ({5'b0, lz} < (p.exp - 10'd1)) ? lz : 5'(p.exp - 10'd1);
			sig = p.sum[26:0] << sh;
			e   = $signed({1'b0, p.exp - {5'b0, sh}});
		end
		return round_pack(p.sign, e, sig, 1'b0);
	endfunction

	function automatic fmul_pre_t fp_mul_pre(input f32_t a, input f32_t b);
		logic [7:0]  ea;
		logic [7:0]  eb;
		logic [23:0] sa;
		logic [23:0] sb;
		fmul_pre_t   p;
		ea = (a[30:23] == 8'h0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'h0) ? 8'd1 : b[30:23];
		sa = {a[30:23] != 8'h0, a[22:0]};
		sb = {b[30:23] != 8'h0, b[22:0]};
		p.sign = a[31] ^ b[31];
		p.inf  = (a[30:23] == 8'hFF) || (b[30:23] == 8'hFF);
		p.exp  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
		p.prod = 48'(sa) * 48'(sb);
		return p;
	endfunction

	function automatic f32_t fp_mul_post(input fmul_pre_t p);
		logic [5:0]         lz;
		logic [5:0]         sh;
		logic [47:0]        pn;
		logic [47:0]        ps;
		logic [48:0]        m;
		logic signed [10:0] e;
		logic               lost;
		if (p.inf)
			return {p.sign, 8'hFF, 23'h0};
		if (p.prod == 48'h0)
			return {p.sign, 31'h0};
		lz = 6'd0;
		for (int i = 0; i < 48; i++)
			if (p.prod[i])
				lz = 6'(47 - i);
		pn = p.prod << lz;
		e  = p.exp - $signed({5'b0, lz});
		sh = 6'd0;
		if (e < 11'sd1)
			sh = (e < -11'sd47) ? 6'd48 : 6'(11'sd1 - e);
		m    = (49'h1 << sh) - 49'h1;
		ps   = pn >> sh;
		lost = |(pn & m[47:0]);
		if (e < 11'sd1)
			e = 11'sd1;
		return round_pack(p.sign, e, ps[47:21], (|ps[20:0]) | lost);
	endfunction

endpackage

// ===== design/ray_box_slab_test_top.sv =====
// Top level of the ray box slab test: ray store, box check, three lanes and merge.
// Box test: one box per cycle unless the output stalls or a ray load is busy.
// Ray load: no result; each lane runs a bit-serial reciprocal, and
// input is held off until the ray commits with no box test in flight.
// Reset clears the stored ray to zero and marks no ray loaded; every box is invalid.
module ray_box_slab_test_top import rbst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, t_lo, t_hi
	input  logic         s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // status, t_near, t_far, zero pad
);

	f32_t a_x, a_y, a_z, b_x, b_y, b_z, t_lo, t_hi;

	logic [8:1] en;
	logic [8:1] v_q;
	logic       busy_q;
	logic       ray_fin_q;
	f32_t       t_min_q, t_max_q;
	logic       fin_pend_q;
	f32_t       t_min_pend_q, t_max_pend_q;
	logic       ok_s1, ok_s2, ok_s3, ok_s4, ok_s5;

	logic       accept, box_in, start, commit, box_ok;
	logic [2:0] lane_busy;
	slab_t      slab_x, slab_y, slab_z;
	logic [1:0] status;
	f32_t       t_near, t_far;

	assign a_x  = s_tdata[31:0];
	assign a_y  = s_tdata[63:32];
	assign a_z  = s_tdata[95:64];
	assign b_x  = s_tdata[127:96];
	assign b_y  = s_tdata[159:128];
	assign b_z  = s_tdata[191:160];
	assign t_lo = s_tdata[223:192];
	assign t_hi = s_tdata[255:224];

	always_comb begin
		en[8] = !v_q[8] || m_tready;
		for (int i = 7; i >= 1; i--)
			en[i] = !v_q[i] || en[i + 1];
	end

	assign s_tready = !busy_q && en[1];
	assign accept   = s_tvalid && s_tready;
	assign box_in   = accept && (s_tuser == MODE_BOX);
	assign start    = accept && (s_tuser == MODE_LOAD);
	assign commit   = busy_q && (lane_busy == 3'b000) && (v_q[7:1] == 7'h0);

	assign box_ok = ray_fin_q
		&& fp_finite(a_x) && fp_finite(a_y) && fp_finite(a_z)
		&& fp_finite(b_x) && fp_finite(b_y) && fp_finite(b_z)
		&& !fp_lt(b_x, a_x) && !fp_lt(b_y, a_y) && !fp_lt(b_z, a_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			busy_q    <= 1'b0;
			ray_fin_q <= 1'b0;
			t_min_q   <= '0;
			t_max_q   <= '0;
		end else begin
			if (en[1])
				v_q[1] <= box_in;
			for (int i = 2; i <= 8; i++)
				if (en[i])
					v_q[i] <= v_q[i - 1];
			if (start)
				busy_q <= 1'b1;
			else if (commit)
				busy_q <= 1'b0;
			if (commit) begin
				ray_fin_q <= fin_pend_q;
				t_min_q   <= t_min_pend_q;
				t_max_q   <= t_max_pend_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fin_pend_q   <= fp_finite(a_x) && fp_finite(a_y) && fp_finite(a_z)
				&& fp_finite(b_x) && fp_finite(b_y) && fp_finite(b_z);
			t_min_pend_q <= t_lo;
			t_max_pend_q <= t_hi;
		end
		if (en[1]) ok_s1 <= box_ok;
		if (en[2]) ok_s2 <= ok_s1;
		if (en[3]) ok_s3 <= ok_s2;
		if (en[4]) ok_s4 <= ok_s3;
		if (en[5]) ok_s5 <= ok_s4;
	end

	rbst_lane u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en[5:1]),
		.start   (start),
		.commit  (commit),
		.org_in  (a_x),
		.dir_in  (b_x),
		.lo      (a_x),
		.hi      (b_x),
		.busy    (lane_busy[0]),
		.slab_s5 (slab_x)
	);

	rbst_lane u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en[5:1]),
		.start   (start),
		.commit  (commit),
		.org_in  (a_y),
		.dir_in  (b_y),
		.lo      (a_y),
		.hi      (b_y),
		.busy    (lane_busy[1]),
		.slab_s5 (slab_y)
	);

	rbst_lane u_lane_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en[5:1]),
		.start   (start),
		.commit  (commit),
		.org_in  (a_z),
		.dir_in  (b_z),
		.lo      (a_z),
		.hi      (b_z),
		.busy    (lane_busy[2]),
		.slab_s5 (slab_z)
	);

	rbst_merge u_merge (
		.clk    (clk),
		.en     (en[8:6]),
		.slab_x (slab_x),
		.slab_y (slab_y),
		.slab_z (slab_z),
		.ok_s5  (ok_s5),
		.t_min  (t_min_q),
		.t_max  (t_max_q),
		.status (status),
		.t_near (t_near),
		.t_far  (t_far)
	);

	assign m_tvalid = v_q[8];
	assign m_tdata  = {6'h00, t_far, t_near, status};

endmodule

// ===== design/rbst_recip.sv =====
// Bit-serial reciprocal of one direction component, one quotient bit per cycle.
module rbst_recip import rbst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  f32_t den,
	output logic busy,
	output f32_t res
);

	localparam int QBITS = 28;

	logic [4:0]  cnt_q;
	logic [24:0] r_q;
	logic [27:0] q_q;
	logic [23:0] m_q;
	logic        sgn_q;
	logic [7:0]  exp_q;

	logic [26:0]        sig;
	logic [26:0]        sig_sh;
	logic               stk;
	logic               lost;
	logic signed [10:0] e;
	logic [1:0]         sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'(QBITS);
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= {1'b1, den[22:0]};
			r_q   <= 25'h0800000;
			q_q   <= '0;
			sgn_q <= den[31];
			exp_q <= den[30:23];
		end else if (cnt_q != 5'd0) begin
			if (r_q >= {1'b0, m_q}) begin
				q_q <= {q_q[26:0], 1'b1};
				r_q <= (r_q - {1'b0, m_q}) << 1;
			end else begin
				q_q <= {q_q[26:0], 1'b0};
				r_q <= r_q << 1;
			end
		end
	end

	always_comb begin
		if (q_q[27]) begin
			sig = q_q[27:1];
			stk = q_q[0] | (r_q != 25'h0);
			e   = 11'sd254 - $signed({3'b0, exp_q});
		end else begin
			sig = q_q[26:0];
			stk = r_q != 25'h0;
			e   = 11'sd253 - $signed({3'b0, exp_q});
		end
		sh = 2'd0;
		if (e < 11'sd1)
			sh = (e < -11'sd1) ? 2'd3 : 2'(11'sd1 - e);
		sig_sh = sig >> sh;
		lost   = |(sig & ((27'h1 << sh) - 27'h1));
		if (e < 11'sd1)
			e = 11'sd1;
		res = round_pack(sgn_q, e, sig_sh, stk | lost);
	end

	assign busy = cnt_q != 5'd0;

endmodule

// ===== design/rbst_lane.sv =====
// One axis lane: stored ray component and the slab distance pipeline for that axis.
module rbst_lane import rbst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [4:0] en,
	input  logic       start,
	input  logic       commit,
	input  f32_t       org_in,
	input  f32_t       dir_in,
	input  f32_t       lo,
	input  f32_t       hi,
	output logic       busy,
	output slab_t      slab_s5
);

	f32_t org_q;
	f32_t inv_q;
	logic par_q;
	f32_t org_pend_q;
	logic par_pend_q;
	f32_t recip_res;

	fadd_pre_t lo_s1, hi_s1;
	f32_t      dlo_s2, dhi_s2;
	fmul_pre_t mlo_s3, mhi_s3;
	f32_t      tlo_s4, thi_s4;
	logic      pmiss_s1, pmiss_s2, pmiss_s3, pmiss_s4;
	f32_t      neg_org;
	logic      swap;

	rbst_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.den    (dir_in),
		.busy   (busy),
		.res    (recip_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0;
			inv_q <= '0;
			par_q <= 1'b0;
		end else if (commit) begin
			org_q <= org_pend_q;
			inv_q <= par_pend_q ? '0 : recip_res;
			par_q <= par_pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			org_pend_q <= org_in;
			par_pend_q <= ({1'b0, dir_in[30:0]} <= PAR_LIMIT);
		end
	end

	assign neg_org = {~org_q[31], org_q[30:0]};
	assign swap    = fp_lt(thi_s4, tlo_s4);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			lo_s1    <= fp_add_pre(lo, neg_org);
			hi_s1    <= fp_add_pre(hi, neg_org);
			pmiss_s1 <= par_q && (fp_lt(org_q, lo) || fp_lt(hi, org_q));
		end
		if (en[1]) begin
			dlo_s2   <= fp_add_post(lo_s1);
			dhi_s2   <= fp_add_post(hi_s1);
			pmiss_s2 <= pmiss_s1;
		end
		if (en[2]) begin
			mlo_s3   <= fp_mul_pre(dlo_s2, inv_q);
			mhi_s3   <= fp_mul_pre(dhi_s2, inv_q);
			pmiss_s3 <= pmiss_s2;
		end
		if (en[3]) begin
			tlo_s4   <= fp_mul_post(mlo_s3);
			thi_s4   <= fp_mul_post(mhi_s3);
			pmiss_s4 <= pmiss_s3;
		end
		if (en[4]) begin
			slab_s5.par   <= par_q;
			slab_s5.pmiss <= pmiss_s4;
			slab_s5.near  <= swap ? thi_s4 : tlo_s4;
			slab_s5.far   <= swap ? tlo_s4 : thi_s4;
		end
	end

endmodule

// ===== design/rbst_merge.sv =====
// Merge stages: fold the three lane slabs into entry and exit distances and a status.
module rbst_merge import rbst_pkg::*; (
	input  logic       clk,
	input  logic [2:0] en,
	input  slab_t      slab_x,
	input  slab_t      slab_y,
	input  slab_t      slab_z,
	input  logic       ok_s5,
	input  f32_t       t_min,
	input  f32_t       t_max,
	output logic [1:0] status,
	output f32_t       t_near,
	output f32_t       t_far
);

	trk_t  trk_in;
	trk_t  trk_s6;
	trk_t  trk_s7;
	trk_t  trk_fin;
	slab_t sy_s6;
	slab_t sz_s6;
	slab_t sz_s7;

	function automatic trk_t slab_step(input trk_t t, input slab_t s);
		trk_t r;
		r = t;
		if (!t.miss) begin
			if (s.par) begin
				r.miss = s.pmiss;
			end else begin
				if (fp_lt(t.enter, s.near))
					r.enter = s.near;
				if (fp_lt(s.far, t.leave))
					r.leave = s.far;
				r.miss = fp_lt(r.leave, r.enter);
			end
		end
		return r;
	endfunction

	always_comb begin
		trk_in.ok    = ok_s5;
		trk_in.miss  = 1'b0;
		trk_in.enter = t_min;
		trk_in.leave = t_max;
	end

	assign trk_fin = slab_step(trk_s7, sz_s7);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			trk_s6 <= slab_step(trk_in, slab_x);
			sy_s6  <= slab_y;
			sz_s6  <= slab_z;
		end
		if (en[1]) begin
			trk_s7 <= slab_step(trk_s6, sy_s6);
			sz_s7  <= sz_s6;
		end
		if (en[2]) begin
			if (!trk_fin.ok) begin
				status <= ST_INVALID;
				t_near <= '0;
				t_far  <= '0;
			end else if (trk_fin.miss) begin
				status <= ST_MISS;
				t_near <= '0;
				t_far  <= '0;
			end else begin
				status <= ST_HIT;
				t_near <= trk_fin.enter;
				t_far  <= trk_fin.leave;
			end
		end
	end

endmodule

// ===== bench/ray_box_slab_test_chk.sv =====
// Checker for the ray box slab test: watches both streams, predicts box results, compares.
module ray_box_slab_test_chk import rbst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [255:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	output int           fails,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		f32_t       t_near;
		f32_t       t_far;
	} box_res_t;

	f32_t     org_q [3];
	f32_t     rcp_q [3];
	logic     flat_q [3];
	f32_t     tmin_q;
	f32_t     tmax_q;
	logic     ray_ok_q;
	box_res_t want_q [$];

	function automatic logic is_fin(input f32_t v);
		return v[30:23] != 8'hFF;
	endfunction

	function automatic logic less(input f32_t a, input f32_t b);
		logic [31:0] ka;
		logic [31:0] kb;
		if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
			return 1'b0;
		if (a[30:0] == 0 && b[30:0] == 0)
			return 1'b0;
		ka = a[31] ? ~a : (a | 32'h80000000);
		kb = b[31] ? ~b : (b | 32'h80000000);
		return ka < kb;
	endfunction

	function automatic real to_real(input f32_t v);
		real r;
		if (v[30:23] == 8'hFF)
			return $bitstoreal({v[31], 11'h7FF, v[22:0], 29'h0});
		if (v[30:23] == 8'h0) begin
			r = real'(v[22:0]) * $bitstoreal({1'b0, 11'd874, 52'h0});
			return v[31] ? -r : r;
		end
		return $bitstoreal({v[31], 11'(v[30:23]) + 11'd896, v[22:0], 29'h0});
	endfunction

	function automatic f32_t to_f32(input real r);
		logic [63:0] d;
		logic [63:0] full;
		logic [63:0] keep;
		logic [63:0] w;
		logic        half;
		logic        sticky;
		int          fe;
		int          sh;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF)
			return {d[63], 8'hFF, (|d[51:0]) ? 23'h400000 : 23'h0};
		if (d[62:0] == 0)
			return {d[63], 31'h0};
		fe   = int'(d[62:52]) - 896;
		full = {11'h0, 1'b1, d[51:0]};
		sh   = (fe >= 1) ? 29 : 30 - fe;
		if (sh > 60)
			sh = 60;
		keep   = full >> sh;
		half   = full[sh-1];
		sticky = (full & ((64'h1 << (sh - 1)) - 1)) != 0;
		w = ((fe >= 1) ? (64'(fe - 1) << 23) : 64'h0) + keep + 64'(half & (sticky | keep[0]));
		if (w >= 64'h7F800000)
			return {d[63], 8'hFF, 23'h0};
		return {d[63], w[30:0]};
	endfunction

	function automatic box_res_t test_box(input f32_t lo [3], input f32_t hi [3]);
		box_res_t res;
		f32_t     te;
		f32_t     tx;
		f32_t     s0;
		f32_t     s1;
		f32_t     sw;
		res = '{ST_INVALID, 32'h0, 32'h0};
		for (int k = 0; k < 3; k++)
			if (!is_fin(lo[k]) || !is_fin(hi[k]) || less(hi[k], lo[k]))
				return res;
		if (!ray_ok_q)
			return res;
		res.status = ST_MISS;
		te = tmin_q;
		tx = tmax_q;
		for (int k = 0; k < 3; k++) begin
			if (flat_q[k]) begin
				if (less(org_q[k], lo[k]) || less(hi[k], org_q[k]))
					return res;
			end else begin
				s0 = to_f32(to_real(to_f32(to_real(lo[k]) - to_real(org_q[k])))
					* to_real(rcp_q[k]));
				s1 = to_f32(to_real(to_f32(to_real(hi[k]) - to_real(org_q[k])))
					* to_real(rcp_q[k]));
				if (less(s1, s0)) begin
					sw = s0;
					s0 = s1;
					s1 = sw;
				end
				if (less(te, s0))
					te = s0;
				if (less(s1, tx))
					tx = s1;
				if (less(tx, te))
					return res;
			end
		end
		return '{ST_HIT, te, tx};
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
		$display("mismatch %s: got %h, want %h at %0t", what, got, exp_v, $realtime);
		fails++;
	endtask

	assign pending = want_q.size();

	always @(posedge clk or negedge arst_n) begin
		f32_t     a [3];
		f32_t     b [3];
		box_res_t w;
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				org_q[k]  = 0;
				rcp_q[k]  = 0;
				flat_q[k] = 0;
			end
			tmin_q   = 0;
			tmax_q   = 0;
			ray_ok_q = 0;
			want_q.delete();
			fails = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (want_q.size() == 0) begin
					report("unexpected word", m_tdata[31:0], 32'h0);
				end else begin
					w = want_q.pop_front();
					if (m_tdata[1:0] != w.status)
						report("status", 32'(m_tdata[1:0]), 32'(w.status));
					if (m_tdata[33:2] != w.t_near)
						report("t_near", m_tdata[33:2], w.t_near);
					if (m_tdata[65:34] != w.t_far)
						report("t_far", m_tdata[65:34], w.t_far);
				end
			end
			if (s_tvalid && s_tready) begin
				for (int k = 0; k < 3; k++) begin
					a[k] = s_tdata[32*k +: 32];
					b[k] = s_tdata[96 + 32*k +: 32];
				end
				if (s_tuser == MODE_BOX) begin
					want_q.push_back(test_box(a, b));
				end else begin
					ray_ok_q = 1;
					for (int k = 0; k < 3; k++) begin
						org_q[k] = a[k];
						if (!is_fin(a[k]) || !is_fin(b[k]))
							ray_ok_q = 0;
						if (b[k][30:0] <= PAR_LIMIT[30:0]) begin
							flat_q[k] = 1;
							rcp_q[k]  = 0;
						end else begin
							flat_q[k] = 0;
							rcp_q[k]  = is_fin(b[k]) ? to_f32(1.0 / to_real(b[k])) : 32'h0;
						end
					end
					tmin_q = s_tdata[223:192];
					tmax_q = s_tdata[255:224];
				end
			end
		end
	end
endmodule

// ===== bench/tb_ray_box_slab_test_top.sv =====
// Testbench top for the ray box slab test: clock, reset, stimulus, back-pressure and verdict.
module tb_ray_box_slab_test_top import rbst_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1000000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	int           fails;
	int           pending;
	int           cycles;
	int           send_idle;
	int           recv_stall;
	logic         hold_req;
	logic         hold_done;

	ray_box_slab_test_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	ray_box_slab_test_chk chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, one long hold when asked
	initial begin
		int hold_cnt;
		hold_cnt  = 0;
		hold_done = 0;
		m_tready  = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done && hold_cnt == 0)
				hold_cnt = 400;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0)
					hold_done = 1;
				m_tready <= 0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	function automatic f32_t mid_f();
		return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
	endfunction

	task automatic send(input logic mode, input logic [255:0] data);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			s_tvalid <= 0;
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tuser  <= mode;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_ray(input f32_t o [3], input f32_t d [3], input f32_t lo, input f32_t hi);
		send(MODE_LOAD, {hi, lo, d[2], d[1], d[0], o[2], o[1], o[0]});
	endtask

	task automatic box(input f32_t lo [3], input f32_t hi [3]);
		send(MODE_BOX, {64'h0, hi[2], hi[1], hi[0], lo[2], lo[1], lo[0]});
	endtask

	task automatic random_ray();
		f32_t o [3];
		f32_t d [3];
		f32_t tl;
		f32_t th;
		for (int k = 0; k < 3; k++) begin
			o[k] = mid_f();
			case ($urandom_range(15))
				0:       d[k] = {1'($urandom), 8'($urandom_range(0, 16'h56)), 23'($urandom)};
				1:       d[k] = {1'($urandom), 31'h0};
				2:       d[k] = ($urandom_range(3) == 0) ? 32'h7FC00000 : 32'($urandom);
				default: d[k] = mid_f();
			endcase
		end
		tl = ($urandom_range(1) == 0) ? 32'h0 : mid_f();
		case ($urandom_range(3))
			0:       th = 32'h7F800000;
			1:       th = 32'h7F7FFFFF;
			default: th = {1'b0, 8'($urandom_range(125, 140)), 23'($urandom)};
		endcase
		load_ray(o, d, tl, th);
	endtask

	task automatic random_box();
		f32_t lo [3];
		f32_t hi [3];
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(9))
				0, 1: begin
					lo[k] = {1'b0, 8'($urandom_range(110, 130)), 23'($urandom)};
					hi[k] = {1'b0, lo[k][30:23] + 8'($urandom_range(1, 4)), 23'($urandom)};
				end
				2: begin
					lo[k] = mid_f();
					hi[k] = mid_f();
				end
				default: begin
					lo[k] = {1'b1, 8'($urandom_range(118, 136)), 23'($urandom)};
					hi[k] = {1'b0, 8'($urandom_range(118, 136)), 23'($urandom)};
				end
			endcase
		end
		box(lo, hi);
	endtask

	task automatic random_phase(input int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(19) == 0) begin
				send(1'($urandom), {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom});
				sent++;
			end else begin
				random_ray();
				sent++;
				repeat ($urandom_range(4, 12)) begin
					random_box();
					sent++;
				end
			end
		end
	endtask

	initial begin
		send_idle  = 0;
		recv_stall = 0;
		hold_req   = 0;
		s_tvalid   = 0;
		s_tuser    = 0;
		s_tdata    = '0;
		arst_n     = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// no ray yet: invalid
		box('{32'hBF800000, 32'hBF800000, 32'hBF800000}, '{32'h3F800000, 32'h3F800000, 32'h3F800000});
		load_ray('{32'h0, 32'h0, 32'h0}, '{32'h3F800000, 32'h40000000, 32'h40800000},
			32'h0, 32'h7F800000);
		box('{32'h3F800000, 32'h3F800000, 32'h3F800000}, '{32'h40000000, 32'h40000000, 32'h40000000});
		box('{32'hC0000000, 32'hC0000000, 32'hC0000000}, '{32'hBF800000, 32'hBF800000, 32'hBF800000});
		// negative direction swaps the slab distances
		load_ray('{32'h0, 32'h0, 32'h0}, '{32'hBF800000, 32'h3F000000, 32'hC0800000},
			32'h0, 32'h7F7FFFFF);
		box('{32'hC0000000, 32'hBF800000, 32'hC0800000}, '{32'h3F800000, 32'h40000000, 32'h40000000});
		// parallel x axis
		load_ray('{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h3F800000, 32'h3F800000}, 32'h0, 32'h7F800000);
		box('{32'hBF800000, 32'h3F800000, 32'h3F800000}, '{32'h3F800000, 32'h40000000, 32'h40000000});
		box('{32'h3F800000, 32'h3F800000, 32'h3F800000}, '{32'h40000000, 32'h40000000, 32'h40000000});
		// bad boxes: infinite corner, NaN corner, min above max
		box('{32'hFF800000, 32'h0, 32'h0}, '{32'h3F800000, 32'h3F800000, 32'h3F800000});
		box('{32'h0, 32'h7FC00000, 32'h0}, '{32'h3F800000, 32'h3F800000, 32'h3F800000});
		box('{32'h0, 32'h0, 32'h40000000}, '{32'h3F800000, 32'h3F800000, 32'h3F800000});
		// non-finite origin
		load_ray('{32'h7F800000, 32'h0, 32'h0}, '{32'h3F800000, 32'h3F800000, 32'h3F800000},
			32'h0, 32'h7F800000);
		box('{32'hBF800000, 32'hBF800000, 32'hBF800000}, '{32'h3F800000, 32'h3F800000, 32'h3F800000});
		// NaN interval bounds
		load_ray('{32'h0, 32'h0, 32'h0}, '{32'h3F800000, 32'h3F800000, 32'h3F800000},
			32'h7FC00000, 32'hFFC00000);
		box('{32'h3F800000, 32'h3F800000, 32'h3F800000}, '{32'h40000000, 32'h40000000, 32'h40000000});
		// extremes
		send(MODE_LOAD, '1);
		send(MODE_BOX, '0);
		send(MODE_LOAD, '0);
		send(MODE_BOX, '0);
		send(MODE_BOX, '1);
		load_ray('{32'hFF7FFFFF, 32'h7F7FFFFF, 32'h1}, '{32'h7F7FFFFF, 32'h2B8CBCCD, 32'h80000001},
			32'hFF800000, 32'h7F800000);
		box('{32'hFF7FFFFF, 32'hFF7FFFFF, 32'h80000001}, '{32'h7F7FFFFF, 32'h7F7FFFFF, 32'h1});
		box('{32'h7F7FFFFF, 32'h0, 32'h0}, '{32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF});

		random_phase(420);
		send_idle = 55;
		random_phase(420);
		send_idle  = 0;
		recv_stall = 55;
		random_phase(420);
		send_idle = 7;
		recv_stall = 7;
		random_phase(420);
		send_idle  = 0;
		recv_stall = 0;
		hold_req   = 1;
		random_phase(250);

		@(negedge clk);
		s_tvalid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== sim.f =====
design/rbst_pkg.sv
design/rbst_recip.sv
design/rbst_lane.sv
design/rbst_merge.sv
design/ray_box_slab_test_top.sv
bench/ray_box_slab_test_chk.sv
bench/tb_ray_box_slab_test_top.sv
